// ===== hdl/sdil_pkg.sv =====
// ----------------------------------------------------------------------------
// sdil_pkg
// Shared types for the sorted descending insertion list.
// ----------------------------------------------------------------------------
package sdil_pkg;

  // One stored or inserted value, two's complement
  localparam int unsigned ValueWidth = 32;

  typedef logic signed [ValueWidth-1:0] value_t;

endpackage

// ===== hdl/sorted_descending_insert_list_top.sv =====
// ----------------------------------------------------------------------------
// sorted_descending_insert_list_top
// Keeps up to DEPTH signed values in descending order and lists the table
// after every insert.
// ----------------------------------------------------------------------------
// A value is taken when start is high and busy is low. The block then walks
// the table once, head to tail, one entry per cycle: each cycle reads the old
// entry from the table memory, compares it with the new value in the single
// shared comparator, and both writes back and emits the entry that belongs at
// that place. An insert therefore holds busy while it walks the table as it
// stands after the insert (1 to DEPTH entries), and its results appear one per
// cycle on result_valid_o, starting in the cycle after the first busy cycle.
// The last beat of a listing carries last_entry_o; every beat of an insert
// into a full table carries dropped_o. Results cannot be stalled and must be
// taken in the cycle they are shown. The table needs no clearing after reset.
module sorted_descending_insert_list_top #(
  parameter int unsigned DEPTH = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  sdil_pkg::value_t new_value_i,
  output logic             result_valid_o,
  output sdil_pkg::value_t entry_value_o,
  output logic             last_entry_o,
  output logic             dropped_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] FullCount = CW'(DEPTH);
  localparam logic [CW-1:0] OneCount  = CW'(1);

  // sequencer states
  localparam logic StIdle = 1'b0;
  localparam logic StRun  = 1'b1;

  logic             state_q, state_d;
  logic [CW-1:0]    count_q, count_d;   // entries before this insert
  logic [CW-1:0]    total_q, total_d;   // entries after this insert
  logic [CW-1:0]    idx_q, idx_d;
  logic             full_q, full_d;
  logic             ins_q, ins_d;       // new value already placed
  sdil_pkg::value_t val_q, val_d;
  sdil_pkg::value_t carry_q, carry_d;   // entry pushed one place down

  logic             accept;
  logic             in_tbl;
  logic             old_lt;
  logic             last_step;
  sdil_pkg::value_t emit;
  logic [CW-1:0]    idx_next;
  logic [AW-1:0]    rd_addr;
  logic [AW-1:0]    wr_addr;
  logic             wr_en;

  // table memory, registered read with write bypass
  sdil_pkg::value_t mem_q [DEPTH];
  sdil_pkg::value_t rdata_q;

  sdil_pkg::value_t res_value_q;
  logic             res_valid_q, res_last_q, res_drop_q;

  assign accept    = start && (state_q == StIdle);
  assign busy      = (state_q != StIdle);
  assign idx_next  = idx_q + OneCount;
  assign in_tbl    = (idx_q < count_q);
  assign last_step = (idx_q == total_q - OneCount);
  assign rd_addr   = (state_q == StIdle) ? '0 : idx_next[AW-1:0];
  assign wr_addr   = idx_q[AW-1:0];
  assign wr_en     = (state_q == StRun);

  sdil_cmp u_cmp (
    .a_i  (rdata_q),
    .b_i  (val_q),
    .lt_o (old_lt)
  );

  // pick the entry for this place; the new value goes before the first
  // smaller entry or at the end of the old table
  always_comb begin
    ins_d   = ins_q;
    carry_d = carry_q;
    emit    = carry_q;
    if (state_q == StRun) begin
      if (!ins_q) begin
        if (in_tbl && !old_lt) begin
          emit = rdata_q;
        end else begin
          emit    = val_q;
          ins_d   = 1'b1;
          carry_d = rdata_q;
        end
      end else begin
        emit    = carry_q;
        carry_d = rdata_q;
      end
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    count_d = count_q;
    total_d = total_q;
    idx_d   = idx_q;
    full_d  = full_q;
    val_d   = val_q;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          state_d = StRun;
          val_d   = new_value_i;
          idx_d   = '0;
          full_d  = (count_q == FullCount);
          total_d = (count_q == FullCount) ? FullCount : count_q + OneCount;
        end
      end
      StRun: begin
        idx_d = idx_next;
        if (last_step) begin
          state_d = StIdle;
          count_d = total_q;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      count_q <= '0;
      total_q <= '0;
      idx_q   <= '0;
      full_q  <= 1'b0;
      ins_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      total_q <= total_d;
      idx_q   <= idx_d;
      full_q  <= full_d;
      ins_q   <= accept ? 1'b0 : ins_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    val_q   <= val_d;
    carry_q <= carry_d;
  end

  // table memory
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= emit;
    end
    if (wr_en && (wr_addr == rd_addr)) begin
      rdata_q <= emit;
    end else begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  // result beat register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= (state_q == StRun);
    end
  end

  always_ff @(posedge clk_i) begin
    res_value_q <= emit;
    res_last_q  <= last_step;
    res_drop_q  <= full_q;
  end

  assign result_valid_o = res_valid_q;
  assign entry_value_o  = res_value_q;
  assign last_entry_o   = res_last_q;
  assign dropped_o      = res_drop_q;

endmodule

// ===== hdl/sdil_cmp.sv =====
// ----------------------------------------------------------------------------
// sdil_cmp
// Shared two's complement signed compare used by the insertion sequencer.
// ----------------------------------------------------------------------------
module sdil_cmp (
  input  sdil_pkg::value_t a_i,
  input  sdil_pkg::value_t b_i,
  output logic             lt_o
);

  // a strictly below b, both signed
  assign lt_o = (a_i < b_i);

endmodule

// ===== hdl/sdil_checker.sv =====
// ----------------------------------------------------------------------------
// sdil_checker
// Port-level checks on the listing sequence, bound to the top level.
// ----------------------------------------------------------------------------
module sdil_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic result_valid_o,
  input logic last_entry_o,
  input logic dropped_o
);

  // an accepted insert always starts work
  a_start_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("accepted insert did not raise busy");

  // a listing runs without gaps until its last beat
  a_listing_contig : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !last_entry_o |=> result_valid_o)
    else $error("gap inside a listing");

  // the last beat is not directly followed by another beat
  a_last_gap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && last_entry_o |=> !result_valid_o)
    else $error("beat right after last entry");

  // the drop flag is constant over one listing
  a_drop_stable : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !last_entry_o |=> $stable(dropped_o))
    else $error("dropped changed inside a listing");

  // mid-listing beats only while the insert is in progress
  a_mid_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !last_entry_o |-> busy)
    else $error("listing beat while idle");

endmodule

bind sorted_descending_insert_list_top sdil_checker u_sdil_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .result_valid_o (result_valid_o),
  .last_entry_o   (last_entry_o),
  .dropped_o      (dropped_o)
);
